// ----- rtl/lbps_pkg.sv -----
package lbps_pkg;

    localparam int REG_COUNT = 8;
    localparam int REG_W     = 17;
    localparam int INDEX_W   = 3;
    localparam int TICKS_W   = 16;
    // scan pointer and scan count reach the pattern length itself, at most 8
    localparam int SCAN_W    = 4;

    localparam logic [REG_W-1:0] STEP_RESET [REG_COUNT] = '{
        17'd500, 17'd500, 17'h1FFFF, 17'h1FFFF,
        17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF
    };

    localparam logic [TICKS_W-1:0] TICKS_RESET = STEP_RESET[0][TICKS_W-1:0];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SCAN,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic start;
        logic tick;
        logic halt;
        logic out_free;
    } seq_ctrl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

endpackage

// ----- rtl/led_blink_pattern_sequencer.sv -----
// an input transfer moves through ST_COUNT and ST_DONE into the result register when
// halted or with no tick; a tick that ends the step adds ST_SCAN, which walks the table
// one item at a time: no new input is taken until ST_DONE hands the result on; the scan
// reads one table entry per cycle through the shared compare path
// reset: asynchronous, active low; table back to 500, 500, then -1, led dark,
// step 0, tick count loaded with 500
module led_blink_pattern_sequencer
    import lbps_pkg::*;
#(
    parameter int PATTERN_LENGTH = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [INDEX_W-1:0] wr_index,
    input  logic [REG_W-1:0]   wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // tick, halt
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata    // led_on, step_now[2:0]
);

    seq_ctrl_t          ctrl;
    seq_stat_t          stat;
    logic [INDEX_W-1:0] rd_index;
    logic [REG_W-1:0]   rd_time;
    logic [REG_W-1:0]   zero_time;
    logic               led;
    logic [INDEX_W-1:0] step;

    logic               tick_reg;
    logic               halt_reg;

    logic               out_valid_reg;
    logic               out_led_reg;
    logic [INDEX_W-1:0] out_step_reg;

    lbps_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .rd_index  (rd_index),
        .rd_time   (rd_time),
        .zero_time (zero_time)
    );

    // input fields held for the whole item, the bus may move on after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= 1'b0;
            halt_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            tick_reg <= s_tdata[0];
            halt_reg <= s_tdata[1];
        end
    end

    assign s_tready      = stat.idle;
    assign ctrl.start    = s_tvalid && s_tready;
    assign ctrl.tick     = tick_reg;
    assign ctrl.halt     = halt_reg;
    assign ctrl.out_free = !out_valid_reg || m_tready;

    lbps_seq #(
        .PATTERN_LENGTH (PATTERN_LENGTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .rd_time   (rd_time),
        .zero_time (zero_time),
        .rd_index  (rd_index),
        .stat      (stat),
        .led       (led),
        .step      (step)
    );

    // result register parts the sequencer from the output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            out_led_reg  <= led;
            out_step_reg <= step;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_step_reg, out_led_reg};

endmodule

// ----- rtl/lbps_table.sv -----
module lbps_table
    import lbps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [INDEX_W-1:0] wr_index,
    input  logic [REG_W-1:0]   wr_data,
    input  logic [INDEX_W-1:0] rd_index,
    output logic [REG_W-1:0]   rd_time,
    output logic [REG_W-1:0]   zero_time
);

    logic [REG_W-1:0] step_time_reg [REG_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < REG_COUNT; k++)
            begin
                step_time_reg[k] <= STEP_RESET[k];
            end
        end
        else if (wr_en)
        begin
            step_time_reg[wr_index] <= wr_data;
        end
    end

    assign rd_time   = step_time_reg[rd_index];
    assign zero_time = step_time_reg[0];

endmodule

// ----- rtl/lbps_seq.sv -----
module lbps_seq
    import lbps_pkg::*;
#(
    parameter int PATTERN_LENGTH = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  seq_ctrl_t          ctrl,
    input  logic [REG_W-1:0]   rd_time,
    input  logic [REG_W-1:0]   zero_time,
    output logic [INDEX_W-1:0] rd_index,
    output seq_stat_t          stat,
    output logic               led,
    output logic [INDEX_W-1:0] step
);

    seq_state_t         state_reg, state_next;
    logic [INDEX_W-1:0] step_reg, step_next;
    logic [TICKS_W-1:0] ticks_reg, ticks_next;
    logic               led_reg, led_next;
    logic [SCAN_W-1:0]  idx_reg, idx_next;
    logic [SCAN_W-1:0]  cnt_reg, cnt_next;

    logic               frozen;
    logic [TICKS_W-1:0] ticks_dec;
    logic               dec_zero;
    logic               wrap;
    logic [INDEX_W-1:0] eff;
    logic [TICKS_W-1:0] eff_val;
    logic [SCAN_W-1:0]  cnt_inc;
    logic               scan_neg0;
    logic               scan_hit;
    logic               scan_out;
    logic               scan_stop;

    // shared decrement and compare path
    assign frozen    = ctrl.halt || !ctrl.tick;
    assign ticks_dec = ticks_reg - TICKS_W'(1);
    assign dec_zero  = (ticks_reg == '0) || (ticks_dec == '0);

    // one table entry looked at per cycle; past the end or negative wraps to step 0
    assign rd_index  = idx_reg[INDEX_W-1:0];
    assign wrap      = (idx_reg >= SCAN_W'(PATTERN_LENGTH)) || rd_time[REG_W-1];
    assign eff       = wrap ? '0 : idx_reg[INDEX_W-1:0];
    assign eff_val   = wrap ? zero_time[TICKS_W-1:0] : rd_time[TICKS_W-1:0];
    assign cnt_inc   = cnt_reg + SCAN_W'(1);
    assign scan_neg0 = zero_time[REG_W-1];
    assign scan_hit  = !scan_neg0 && (eff_val != '0);
    assign scan_out  = cnt_inc == SCAN_W'(PATTERN_LENGTH);
    assign scan_stop = scan_neg0 || scan_hit || scan_out;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (frozen || !dec_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_stop)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (ctrl.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        stat.idle = 1'b0;
        stat.done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                stat.idle = 1'b1;
            end
            ST_DONE:
            begin
                stat.done = ctrl.out_free;
            end
            default:
            begin
                stat.idle = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        step_next  = step_reg;
        ticks_next = ticks_reg;
        led_next   = led_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_COUNT:
            begin
                if (!frozen)
                begin
                    if (ticks_reg != '0)
                    begin
                        ticks_next = ticks_dec;
                        led_next   = ~step_reg[0];
                    end
                    idx_next = {1'b0, step_reg} + SCAN_W'(1);
                    cnt_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (scan_neg0)
                begin
                    step_next  = '0;
                    ticks_next = '0;
                end
                else if (scan_hit)
                begin
                    step_next  = eff;
                    ticks_next = eff_val;
                    led_next   = ~eff[0];
                end
                else
                begin
                    step_next = eff;
                    idx_next  = {1'b0, eff} + SCAN_W'(1);
                    cnt_next  = cnt_inc;
                    if (scan_out)
                    begin
                        ticks_next = '0;
                    end
                end
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            ticks_reg <= TICKS_RESET;
            led_reg   <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ticks_reg <= ticks_next;
            led_reg   <= led_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign led  = led_reg;
    assign step = step_reg;

endmodule

// ----- rtl/lbps_checker.sv -----
module lbps_checker
#(
    parameter int PATTERN_LENGTH = 8
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // a halted item skips the scan and goes from ST_COUNT through ST_DONE to the result register
    a_halt_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[1] && !m_tvalid |-> ##3 m_tvalid)
        else $error("halted item result late");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:1] < PATTERN_LENGTH) && (m_tdata[7:4] == 4'b0000))
        else $error("step index out of range or pad bits set");

endmodule

bind led_blink_pattern_sequencer lbps_checker #(
    .PATTERN_LENGTH (PATTERN_LENGTH)
) u_lbps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sv/led_blink_pattern_checker.sv -----
module led_blink_pattern_checker
    import lbps_pkg::*;
#(
    parameter int PATTERN_LENGTH = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [INDEX_W-1:0] wr_index,
    input  logic [REG_W-1:0]   wr_data,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,   // tick, halt
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [7:0]         m_tdata,   // led_on, step_now[2:0]
    output int                 mismatches,
    output int                 awaited
);

    typedef struct packed {
        logic [INDEX_W-1:0] step_now;
        logic               led_on;
    } led_view_t;

    logic [REG_W-1:0]   durations [REG_COUNT];
    logic [INDEX_W-1:0] cur_step;
    logic [TICKS_W-1:0] ticks_to_go;
    logic               lit;
    led_view_t          led_forecast_q [$];

    // move to the next step with a nonzero duration, wrapping on end marks
    function automatic void seek_next_step();
        int idx;
        int n;
        idx = int'(cur_step) + 1;
        for (n = 0; n < PATTERN_LENGTH; n++)
        begin
            if (idx >= PATTERN_LENGTH)
                idx = 0;
            else if (durations[idx][REG_W-1])
                idx = 0;
            if (durations[0][REG_W-1])
            begin
                cur_step    = '0;
                ticks_to_go = '0;
                return;
            end
            if (durations[idx][TICKS_W-1:0] != '0)
            begin
                cur_step    = idx[INDEX_W-1:0];
                ticks_to_go = durations[idx][TICKS_W-1:0];
                lit         = ~idx[0];
                return;
            end
            cur_step = idx[INDEX_W-1:0];
            idx++;
        end
        // nothing playable in the table
        ticks_to_go = '0;
    endfunction

    function automatic led_view_t predict_led(input logic tick, input logic halt);
        led_view_t view;
        if (!halt && tick)
        begin
            if (ticks_to_go != '0)
            begin
                ticks_to_go--;
                lit = ~cur_step[0];
            end
            if (ticks_to_go == '0)
                seek_next_step();
        end
        view.led_on   = lit;
        view.step_now = cur_step;
        return view;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        led_view_t got;
        led_view_t want;
        if (!rst_n)
        begin
            durations   = STEP_RESET;
            cur_step    = '0;
            ticks_to_go = STEP_RESET[0][REG_W-1] ? '0 : STEP_RESET[0][TICKS_W-1:0];
            lit         = 1'b0;
            mismatches  = 0;
            led_forecast_q.delete();
        end
        else
        begin
            if (wr_en)
                durations[wr_index] = wr_data;
            if (s_tvalid && s_tready)
                led_forecast_q.push_back(predict_led(s_tdata[0], s_tdata[1]));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[3:0];
                if (led_forecast_q.size() == 0)
                begin
                    $error("led_on/step_now: unexpected transfer, got %0d/%0d",
                           got.led_on, got.step_now);
                    mismatches++;
                end
                else
                begin
                    want = led_forecast_q.pop_front();
                    if (got.led_on !== want.led_on)
                    begin
                        $error("led_on: expected %0d, got %0d", want.led_on, got.led_on);
                        mismatches++;
                    end
                    if (got.step_now !== want.step_now)
                    begin
                        $error("step_now: expected %0d, got %0d",
                               want.step_now, got.step_now);
                        mismatches++;
                    end
                end
            end
        end
        awaited = led_forecast_q.size();
    end

endmodule

// ----- tb/sv/led_blink_pattern_sequencer_tb.sv -----
module led_blink_pattern_sequencer_tb;
    import lbps_pkg::*;

    localparam int PATTERN_LENGTH = 8;
    localparam int WARMUP_TICKS   = 510;
    localparam int PHASES         = 11;
    localparam int PHASE_ITEMS    = 100;
    localparam int HOLD_START     = 1200;
    localparam int HOLD_LEN       = 200;
    localparam int CALM_START     = 6000;
    localparam int CALM_END       = 9000;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 20;

    localparam logic [REG_W-1:0] DUR_END = '1;
    localparam logic [REG_W-1:0] DUR_MAX = 17'd65535;

    localparam logic [REG_W-1:0] PAT_SHORT [REG_COUNT] = '{
        17'd1, 17'd0, 17'd2, DUR_END, DUR_END, DUR_END, DUR_END, DUR_END
    };
    localparam logic [REG_W-1:0] PAT_ZERO [REG_COUNT] = '{default: '0};
    localparam logic [REG_W-1:0] PAT_HEADLESS [REG_COUNT] = '{
        DUR_END, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1
    };
    localparam logic [REG_W-1:0] PAT_FULL [REG_COUNT] = '{
        17'd3, 17'd1, 17'd0, 17'd0, 17'd1, 17'd1, 17'd0, 17'd2
    };
    localparam logic [REG_W-1:0] PAT_LONG [REG_COUNT] = '{
        DUR_MAX, 17'd1, DUR_END, DUR_END, DUR_END, DUR_END, DUR_END, DUR_END
    };

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               wr_en    = 1'b0;
    logic [INDEX_W-1:0] wr_index = '0;
    logic [REG_W-1:0]   wr_data  = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = '0;   // tick, halt
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata;         // led_on, step_now[2:0]
    int                 mismatches;
    int                 awaited;

    led_blink_pattern_sequencer #(
        .PATTERN_LENGTH (PATTERN_LENGTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    led_blink_pattern_checker #(
        .PATTERN_LENGTH (PATTERN_LENGTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // called right after a rising edge, returns right after the transfer edge or after a random idle gap behind it
    task automatic put_item(input logic tick, input logic halt, input bit may_idle);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, halt, tick};
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        if (may_idle && $urandom_range(0, 99) < 17)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (awaited != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic load_pattern(input logic [REG_W-1:0] pattern [REG_COUNT]);
        int k;
        for (k = 0; k < REG_COUNT; k++)
        begin
            wr_en    <= 1'b1;
            wr_index <= k[INDEX_W-1:0];
            wr_data  <= pattern[k];
            @(posedge clk);
        end
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: random stalls, one long hold-off and one calm stretch
    initial
    begin
        int cyc;
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
                m_tready <= 1'b0;
            else if (cyc >= CALM_START && cyc < CALM_END)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 17);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        logic [REG_W-1:0] pattern [REG_COUNT];
        int phase;
        int i;
        int k;
        int roll;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset table: every tick/halt mix, led dark until the first tick
        put_item(1'b0, 1'b0, 1'b1);
        put_item(1'b1, 1'b1, 1'b1);
        put_item(1'b0, 1'b1, 1'b1);
        put_item(1'b1, 1'b0, 1'b1);
        put_item(1'b1, 1'b0, 1'b1);
        wait_drained();

        // edit the table mid-step; it only shows once the reset step runs out
        load_pattern(PAT_SHORT);
        repeat (WARMUP_TICKS) put_item(1'b1, 1'b0, 1'b1);
        put_item(1'b0, 1'b0, 1'b1);
        put_item(1'b1, 1'b1, 1'b1);
        wait_drained();

        // nothing playable: scan falls through, led holds
        load_pattern(PAT_ZERO);
        repeat (4) put_item(1'b1, 1'b0, 1'b1);
        wait_drained();

        // step 0 ends the pattern: stuck on step 0
        load_pattern(PAT_HEADLESS);
        repeat (3) put_item(1'b1, 1'b0, 1'b1);
        wait_drained();

        // zero steps skipped, step 7 reached, wrap at table end
        load_pattern(PAT_FULL);
        repeat (10) put_item(1'b1, 1'b0, 1'b1);

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            for (k = 0; k < REG_COUNT; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 15)
                    pattern[k] = '0;
                else if (roll < 30)
                    pattern[k] = DUR_END;
                else if (roll < 85)
                    pattern[k] = REG_W'($urandom_range(1, 6));
                else
                    pattern[k] = REG_W'($urandom_range(7, 400));
            end
            load_pattern(pattern);
            for (i = 0; i < PHASE_ITEMS; i++)
                put_item($urandom_range(0, 99) < 75, $urandom_range(0, 99) < 12,
                         !(phase == 4 || phase == 5));
        end

        // longest step the counter holds
        wait_drained();
        load_pattern(PAT_LONG);
        repeat (6) put_item(1'b1, 1'b0, 1'b1);
        put_item(1'b0, 1'b1, 1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
